@@ rtl/rgb2ycc_pkg.sv @@
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
package rgb2ycc_pkg;

	localparam int PIX_W  = 8;
	localparam int CFG_W  = 13;
	localparam int ROW_W  = 12;
	localparam int SUM_W  = PIX_W + 1;
	localparam int LINE_W = 3 * SUM_W;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1920;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;
	localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 13'd4096;

	// BT.601 weights, Q14; chroma weights are stored as magnitudes
	localparam int Y_R  = 4899;
	localparam int Y_G  = 9617;
	localparam int Y_B  = 1868;
	localparam int CB_R = 2763;
	localparam int CB_G = 5425;
	localparam int CR_G = 6855;
	localparam int CR_B = 1327;
	localparam int FRAC_W = 14;
	localparam int LUMA_ROUND  = 8192;
	localparam int CHROMA_BIAS = 128 << FRAC_W;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic             chroma_valid;
		logic [PIX_W-1:0] blue_diff;
		logic [PIX_W-1:0] red_diff;
		logic             frame_end;
	} ycc_word_t;

endpackage

@@ rtl/rgb_to_ycbcr420_converter.sv @@
// RGB to YCbCr 4:2:0 converter: luma per pixel, chroma per 2x2 block via a line store.
//
// Pixels enter on in_data/in_valid/in_ready in raster order, one word per pixel.
// Every pixel gives one output word on out_data/out_valid/out_ready: its luma,
// and on each odd row and odd column the Cb/Cr of the 2x2 block it closes
// (chroma_valid high, else blue_diff and red_diff are zero). frame_end marks
// the last pixel of a frame. frame_width and frame_height are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block is
// idle; the block does not enforce it. Throughput is one pixel per clock while
// the output is not stalled: the line store takes one access per odd column, a
// write on even rows or a read on odd rows, with the read data registered in stage 1.
// Each pipeline stage holds its word while the next stage is full and stalled,
// so a stalled receiver first fills the empty stages; in_ready falls only when
// all four stages hold words.
// Reset clears the pipeline, the row and column position and the previous
// pixel, and loads width 1920 and height 1080. The line store is not cleared:
// an odd row reads the entries its even row wrote.
module rgb_to_ycbcr420_converter #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [rgb2ycc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgb2ycc_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  rgb2ycc_pkg::pixel_t                    in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output rgb2ycc_pkg::ycc_word_t                 out_data
);

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CMP_W = (CW + 1 > rgb2ycc_pkg::CFG_W) ? CW + 1 : rgb2ycc_pkg::CFG_W;
	localparam int PW = rgb2ycc_pkg::PIX_W;
	localparam int SW = rgb2ycc_pkg::SUM_W;
	localparam int RW = rgb2ycc_pkg::ROW_W;
	localparam int LW = rgb2ycc_pkg::LINE_W;

	function automatic logic [PW-1:0] clip_q14(input logic [23:0] v);
		logic [PW-1:0] res;
		if (v[23]) begin
			res = '0;
		end else if (v[22]) begin
			res = '1;
		end else begin
			res = v[21:14];
		end
		return res;
	endfunction

	// configuration
	logic [rgb2ycc_pkg::CFG_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgb2ycc_pkg::WIDTH_RESET;
			height_q <= rgb2ycc_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgb2ycc_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata;
				rgb2ycc_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata;
			endcase
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en_s1, en_s2, en_s3, en_out;
	logic accept;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign accept   = in_valid && in_ready;

	// raster position
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	rgb2ycc_pkg::pixel_t prior_q;
	logic [CMP_W-1:0] col_next;
	logic [rgb2ycc_pkg::CFG_W-1:0] row_next;
	logic col_end, row_end;

	assign col_next = CMP_W'(col_q) + CMP_W'(1);
	assign col_end  = (col_next >= CMP_W'(width_q)) || (col_next >= CMP_W'(MAX_WIDTH));
	assign row_next = rgb2ycc_pkg::CFG_W'(row_q) + rgb2ycc_pkg::CFG_W'(1);
	assign row_end  = (row_next >= height_q) || (row_next >= rgb2ycc_pkg::HEIGHT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prior_q <= '0;
		end else if (accept) begin
			prior_q <= in_data;
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line store of pair sums: even rows write, odd rows read
	logic [SW-1:0] sum_r, sum_g, sum_b;
	logic [AW-1:0] line_addr;
	logic          line_we, line_re;
	logic [LW-1:0] line_mem [LINE_DEPTH];
	logic [LW-1:0] line_rd_s1;

	assign sum_r     = SW'(prior_q.red)   + SW'(in_data.red);
	assign sum_g     = SW'(prior_q.green) + SW'(in_data.green);
	assign sum_b     = SW'(prior_q.blue)  + SW'(in_data.blue);
	assign line_addr = AW'(col_q >> 1);
	assign line_we   = accept && col_q[0] && !row_q[0];
	assign line_re   = accept && col_q[0] && row_q[0];

	// the write of an entry always lands a full row before its read, no forwarding
	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_addr] <= {sum_r, sum_g, sum_b};
		end
		if (line_re) begin
			line_rd_s1 <= line_mem[line_addr];
		end
	end

	// stage 1: luma products, pair sums
	logic [20:0]   yr_s1;
	logic [21:0]   yg_s1;
	logic [18:0]   yb_s1;
	logic [SW-1:0] sr_s1, sg_s1, sb_s1;
	logic          chroma_s1, fend_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			yr_s1     <= 21'(int'(in_data.red)   * rgb2ycc_pkg::Y_R);
			yg_s1     <= 22'(int'(in_data.green) * rgb2ycc_pkg::Y_G);
			yb_s1     <= 19'(int'(in_data.blue)  * rgb2ycc_pkg::Y_B);
			sr_s1     <= sum_r;
			sg_s1     <= sum_g;
			sb_s1     <= sum_b;
			chroma_s1 <= col_q[0] && row_q[0];
			fend_s1   <= col_end && row_end;
		end
	end

	// stage 2: luma rounding, block averages
	logic [23:0]   ysum;
	logic [SW:0]   tot_r, tot_g, tot_b;
	logic [PW-1:0] luma_s2, ar_s2, ag_s2, ab_s2;
	logic          chroma_s2, fend_s2;

	assign ysum  = 24'(yr_s1) + 24'(yg_s1) + 24'(yb_s1) + 24'(rgb2ycc_pkg::LUMA_ROUND);
	assign tot_r = (SW+1)'(sr_s1) + (SW+1)'(line_rd_s1[3*SW-1:2*SW]) + (SW+1)'(2);
	assign tot_g = (SW+1)'(sg_s1) + (SW+1)'(line_rd_s1[2*SW-1:SW]) + (SW+1)'(2);
	assign tot_b = (SW+1)'(sb_s1) + (SW+1)'(line_rd_s1[SW-1:0]) + (SW+1)'(2);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			luma_s2   <= clip_q14(ysum);
			ar_s2     <= tot_r[SW:2];
			ag_s2     <= tot_g[SW:2];
			ab_s2     <= tot_b[SW:2];
			chroma_s2 <= chroma_s1;
			fend_s2   <= fend_s1;
		end
	end

	// stage 3: chroma products
	logic [19:0]   cbr_s3;
	logic [20:0]   cbg_s3, crg_s3;
	logic [18:0]   crb_s3;
	logic [PW-1:0] ar_s3, ab_s3, luma_s3;
	logic          chroma_s3, fend_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			cbr_s3    <= 20'(int'(ar_s2) * rgb2ycc_pkg::CB_R);
			cbg_s3    <= 21'(int'(ag_s2) * rgb2ycc_pkg::CB_G);
			crg_s3    <= 21'(int'(ag_s2) * rgb2ycc_pkg::CR_G);
			crb_s3    <= 19'(int'(ab_s2) * rgb2ycc_pkg::CR_B);
			ar_s3     <= ar_s2;
			ab_s3     <= ab_s2;
			luma_s3   <= luma_s2;
			chroma_s3 <= chroma_s2;
			fend_s3   <= fend_s2;
		end
	end

	// output stage: biased sums, floor shift and clip
	logic [23:0] cb_sum, cr_sum;
	rgb2ycc_pkg::ycc_word_t out_q;

	assign cb_sum = (24'(ab_s3) << 13) + 24'(rgb2ycc_pkg::CHROMA_BIAS)
		- 24'(cbr_s3) - 24'(cbg_s3);
	assign cr_sum = (24'(ar_s3) << 13) + 24'(rgb2ycc_pkg::CHROMA_BIAS)
		- 24'(crg_s3) - 24'(crb_s3);

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			out_q.luma         <= luma_s3;
			out_q.chroma_valid <= chroma_s3;
			out_q.blue_diff    <= chroma_s3 ? clip_q14(cb_sum) : '0;
			out_q.red_diff     <= chroma_s3 ? clip_q14(cr_sum) : '0;
			out_q.frame_end    <= fend_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// input only stalls once every stage is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && out_valid_q && !out_ready))
		else $error("input stalled with a free pipeline stage");

	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.chroma_valid) |-> (out_data.blue_diff == '0 &&
		out_data.red_diff == '0))
		else $error("chroma fields set without a completed block");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		line_re |=> (v_s1 && chroma_s1))
		else $error("line store read data without its pixel in stage 1");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && col_end && row_end) |=> (col_q == '0 && row_q == '0))
		else $error("position not cleared after the last pixel of a frame");

endmodule
